/* hw/rtl/lbs_pkg.sv */
// shared types, constants and saturation helpers for the skinning core
// no dependencies; imported by linear_blend_skinning_core and the testbench
`timescale 1ns / 1ps

package lbs_pkg;

	localparam int MAX_JOINTS_DEF = 32;
	localparam int XFORM_WORDS    = 3 * 4;
	localparam int JOINT_W        = 5;
	localparam int ELEM_W         = 4;
	localparam int COEF_W         = 32;
	localparam int POS_W          = 32;
	localparam int WEIGHT_W       = 17;
	localparam int ACC_W          = 48;
	localparam int DOT_W          = ACC_W + 3;
	localparam int S_TDATA_W      = 160;
	localparam int M_TDATA_W      = 96;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

	// tuser codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_MAC  = 1'b1;

	// lane 3 of a row is the translation term, last axis is z
	localparam logic [1:0] LANE_OFFSET = 2'd3;
	localparam logic [1:0] LANE_FIRST  = 2'd0;
	localparam logic [1:0] AXIS_Z      = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} lbs_state_t;

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [DOT_W-1:0] v);
		logic [DOT_W-ACC_W:0] hi;
		hi = v[DOT_W-1:ACC_W-1];
		if (hi == '0 || hi == '1) begin
			return v[ACC_W-1:0];
		end else if (v[DOT_W-1]) begin
			return {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			return {1'b0, {(ACC_W-1){1'b1}}};
		end
	endfunction

	function automatic logic [POS_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-POS_W:0] hi;
		hi = v[ACC_W-1:POS_W-1];
		if (hi == '0 || hi == '1) begin
			return v[POS_W-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			return {1'b0, {(POS_W-1){1'b1}}};
		end
	endfunction

endpackage

/* hw/rtl/lbs_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies; holds the joint transform words
`timescale 1ns / 1ps

module lbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/linear_blend_skinning_core.sv */
// a valid load word is written to the transform ram on accept; a contribution word reads
// the 12 words of its joint transform through the one read port, weights each row dot
// product and adds it to its axis accumulator; a zero weight or out of range joint adds
// nothing; a last word then moves the sums into the result word and clears them;
// one word in flight; a last word waits on an unread result
// reset clears control and the accumulators; the transform ram is not cleared
`timescale 1ns / 1ps

module linear_blend_skinning_core #(
	parameter int MAX_JOINTS = lbs_pkg::MAX_JOINTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// joint[4:0] element[8:5] coef_value[40:9] pos_x[72:41] pos_y[104:73]
	// pos_z[136:105] weight[153:137] zero pad[159:154]
	input  logic [lbs_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// func
	input  logic                           s_axis_tuser,
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// out_x[31:0] out_y[63:32] out_z[95:64]
	output logic [lbs_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

	import lbs_pkg::*;

	localparam int STORE_DEPTH = MAX_JOINTS * XFORM_WORDS;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int CALC_W      = (AW > JOINT_W + 4) ? AW : JOINT_W + 4;
	localparam int CNT_W       = $clog2(XFORM_WORDS + 1);

	// input fields
	logic [JOINT_W-1:0]         in_joint;
	logic [ELEM_W-1:0]          in_element;
	logic [COEF_W-1:0]          in_coef;
	logic [POS_W-1:0]           in_pos [3];
	logic [WEIGHT_W-1:0]        in_weight;
	logic [WEIGHT_W-1:0]        w_sat;
	logic                       joint_ok;
	logic                       elem_ok;
	logic                       contrib_live;

	assign in_joint   = s_axis_tdata[4:0];
	assign in_element = s_axis_tdata[8:5];
	assign in_coef    = s_axis_tdata[40:9];
	assign in_pos[0]  = s_axis_tdata[72:41];
	assign in_pos[1]  = s_axis_tdata[104:73];
	assign in_pos[2]  = s_axis_tdata[136:105];
	assign in_weight  = s_axis_tdata[153:137];

	assign w_sat        = (in_weight > WEIGHT_ONE) ? WEIGHT_ONE : in_weight;
	assign joint_ok     = int'(in_joint) < MAX_JOINTS;
	assign elem_ok      = in_element < ELEM_W'(XFORM_WORDS);
	assign contrib_live = (w_sat != '0) && joint_ok;

	lbs_state_t state_q, state_d;

	logic accept;
	logic ram_we;
	logic ram_re;
	logic fin_fire;
	logic run_done;

	logic [CALC_W-1:0] wr_calc;
	logic [CALC_W-1:0] base_calc;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic [COEF_W-1:0] rd_data;

	// per-item payload
	logic [AW-1:0]       base_q;
	logic [POS_W-1:0]    pos_q [3];
	logic [WEIGHT_W-1:0] w_q;
	logic                last_q;
	logic [CNT_W-1:0]    rd_cnt_q;

	// pipeline
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [3:0]               tag_s1, tag_s2;
	logic [1:0]               axis_s3, axis_s4, axis_s5;
	logic signed [63:0]       prod_s2;
	logic signed [DOT_W-1:0]  dot_q;
	logic signed [ACC_W-1:0]  dot_s3;
	logic signed [49:0]       mh_s4;
	logic [32:0]              ml_s4;
	logic signed [49:0]       term_s5;

	logic signed [ACC_W-1:0]  acc_q [3];
	logic                     out_v_q;
	logic [M_TDATA_W-1:0]     out_data_q;

	logic signed [32:0]       mul_b;
	logic signed [64:0]       mul_full;
	logic signed [ACC_W-1:0]  term48;
	logic signed [DOT_W-1:0]  term_ext;
	logic signed [DOT_W-1:0]  dot_sum;
	logic signed [DOT_W-1:0]  acc_sum;

	assign wr_calc   = CALC_W'(in_joint) * CALC_W'(XFORM_WORDS) + CALC_W'(in_element);
	assign base_calc = CALC_W'(in_joint) * CALC_W'(XFORM_WORDS);
	assign wr_addr   = wr_calc[AW-1:0];
	assign rd_addr   = base_q + AW'(rd_cnt_q);

	lbs_ram #(
		.WIDTH (COEF_W),
		.DEPTH (STORE_DEPTH)
	) u_xform_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata (in_coef),
		.re    (ram_re),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign run_done = v_s5 && (axis_s5 == AXIS_Z);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid && s_axis_tuser == FUNC_MAC) begin
					if (contrib_live) begin
						state_d = ST_RUN;
					end else if (s_axis_tlast) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_RUN: begin
				if (run_done) begin
					state_d = last_q ? ST_FIN : ST_IDLE;
				end
			end
			ST_FIN: begin
				if (!out_v_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready = 1'b0;
		ram_re        = 1'b0;
		fin_fire      = 1'b0;
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_RUN:  ram_re = (rd_cnt_q != CNT_W'(XFORM_WORDS));
			ST_FIN:  fin_fire = !out_v_q || m_axis_tready;
			default: s_axis_tready = 1'b0;
		endcase
	end

	assign accept = s_axis_tvalid && s_axis_tready;
	assign ram_we = accept && (s_axis_tuser == FUNC_LOAD) && joint_ok && elem_ok;

	// lane 3 scales the offset by one so every lane floors the same way
	always_comb begin
		unique case (tag_s1[1:0])
			2'd0:        mul_b = {pos_q[0][POS_W-1], pos_q[0]};
			2'd1:        mul_b = {pos_q[1][POS_W-1], pos_q[1]};
			2'd2:        mul_b = {pos_q[2][POS_W-1], pos_q[2]};
			LANE_OFFSET: mul_b = 33'sd65536;
			default:     mul_b = '0;
		endcase
	end

	assign mul_full = $signed(rd_data) * mul_b;
	assign term48   = prod_s2[63:16];
	assign term_ext = {{(DOT_W-ACC_W){term48[ACC_W-1]}}, term48};
	assign dot_sum  = ((tag_s2[1:0] == LANE_FIRST) ? '0 : dot_q) + term_ext;
	assign acc_sum  = {{(DOT_W-ACC_W){acc_q[axis_s5][ACC_W-1]}}, acc_q[axis_s5]}
		+ {term_s5[49], term_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_cnt_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			out_v_q  <= 1'b0;
			acc_q[0] <= '0;
			acc_q[1] <= '0;
			acc_q[2] <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				rd_cnt_q <= '0;
			end else if (ram_re) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			v_s1 <= ram_re;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && (tag_s2[1:0] == LANE_OFFSET);
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (fin_fire) begin
				out_v_q  <= 1'b1;
				acc_q[0] <= '0;
				acc_q[1] <= '0;
				acc_q[2] <= '0;
			end else begin
				if (m_axis_tready) begin
					out_v_q <= 1'b0;
				end
				if (v_s5) begin
					acc_q[axis_s5] <= sat_acc(acc_sum);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q    <= base_calc[AW-1:0];
			pos_q[0]  <= in_pos[0];
			pos_q[1]  <= in_pos[1];
			pos_q[2]  <= in_pos[2];
			w_q       <= w_sat;
			last_q    <= s_axis_tlast;
		end
		tag_s1  <= rd_cnt_q[3:0];
		tag_s2  <= tag_s1;
		prod_s2 <= mul_full[63:0];
		if (v_s2) begin
			dot_q <= dot_sum;
		end
		dot_s3  <= sat_acc(dot_sum);
		axis_s3 <= tag_s2[3:2];
		// floor(dot * w / 2^16) split as hi * w + floor(lo * w / 2^16)
		mh_s4   <= $signed(dot_s3[ACC_W-1:16]) * $signed({1'b0, w_q});
		ml_s4   <= dot_s3[15:0] * w_q;
		axis_s4 <= axis_s3;
		term_s5 <= mh_s4 + $signed({33'b0, ml_s4[32:16]});
		axis_s5 <= axis_s4;
		if (fin_fire) begin
			out_data_q <= {sat_out(acc_q[2]), sat_out(acc_q[1]), sat_out(acc_q[0])};
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("transform ram written while a contribution reads it");

	a_acc_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> state_q == ST_RUN)
		else $error("accumulator update outside of a contribution");

	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5))
		else $error("result taken while the pipeline still holds work");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !(v_s1 || v_s5) && !ram_re)
		else $error("new word accepted while a contribution is in flight");
`endif

endmodule

/* tb/testbench.sv */
// self-checking bench for linear_blend_skinning_core: transform loads and weighted
// joint contributions in, skinned vertices out, checked against a local blend model
// depends on lbs_pkg and linear_blend_skinning_core
`timescale 1ns / 1ps

module testbench;
	import lbs_pkg::*;

	localparam int ITEM_TARGET  = 750;
	localparam int CHUNK_ITEMS  = 50;
	localparam int CALM_ITEMS   = 100;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int STORE_WORDS  = MAX_JOINTS_DEF * XFORM_WORDS;
	localparam int TOP_JOINT    = MAX_JOINTS_DEF - 1;

	localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam longint OUT_HI = 64'sh0000_0000_7FFF_FFFF;
	localparam longint OUT_LO = -OUT_HI - 1;

	typedef struct packed {
		logic                func;
		logic [JOINT_W-1:0]  joint;
		logic [ELEM_W-1:0]   element;
		logic [COEF_W-1:0]   coef;
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_y;
		logic [POS_W-1:0]    pos_z;
		logic [WEIGHT_W-1:0] weight;
		logic                last;
	} blend_word_t;

	typedef struct packed {
		logic [POS_W-1:0] z;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] x;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = FUNC_LOAD;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;

	blend_word_t pending_words[$];
	vertex_t expected_vertices[$];
	blend_word_t cur_word;

	// model state: transform copy and the three accumulators
	bit [COEF_W-1:0] xform_copy [STORE_WORDS];
	longint acc_x = 0;
	longint acc_y = 0;
	longint acc_z = 0;

	// stimulus side bookkeeping: which transform words have been written
	bit [XFORM_WORDS-1:0] gen_loaded [MAX_JOINTS_DEF];
	bit gen_listed [MAX_JOINTS_DEF];
	int ready_joints[$];
	int stim_count = 0;

	bit calm = 1'b0;
	bit hold_start = 1'b0;
	int hold_left;
	int send_gap;
	int sink_gap;
	int fail_count = 0;
	int cycles_run;

	linear_blend_skinning_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint clamp_acc(input longint v);
		if (v > ACC_HI) begin
			return ACC_HI;
		end else if (v < ACC_LO) begin
			return ACC_LO;
		end
		return v;
	endfunction

	function automatic logic [POS_W-1:0] clamp_out(input longint v);
		longint c;
		c = v;
		if (c > OUT_HI) begin
			c = OUT_HI;
		end else if (c < OUT_LO) begin
			c = OUT_LO;
		end
		return c[POS_W-1:0];
	endfunction

	// weight * (row . [x y z 1]); each product floored to q16.16 before the sum
	function automatic longint row_term(input int base, input blend_word_t w, input longint pw);
		longint dot;
		dot = longint'($signed(xform_copy[base + int'(LANE_OFFSET)]));
		dot += (longint'($signed(w.pos_x)) * longint'($signed(xform_copy[base]))) >>> 16;
		dot += (longint'($signed(w.pos_y)) * longint'($signed(xform_copy[base + 1]))) >>> 16;
		dot += (longint'($signed(w.pos_z)) * longint'($signed(xform_copy[base + 2]))) >>> 16;
		dot = clamp_acc(dot);
		return (dot * pw) >>> 16;
	endfunction

	function automatic bit blend_word(input blend_word_t w, output vertex_t v);
		longint pw;
		int base;
		v = '0;
		if (w.func == FUNC_LOAD) begin
			if (int'(w.element) < XFORM_WORDS && int'(w.joint) < MAX_JOINTS_DEF) begin
				xform_copy[int'(w.joint) * XFORM_WORDS + int'(w.element)] = w.coef;
			end
			return 1'b0;
		end
		pw = (w.weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(w.weight);
		if (pw != 0 && int'(w.joint) < MAX_JOINTS_DEF) begin
			base = int'(w.joint) * XFORM_WORDS;
			acc_x = clamp_acc(acc_x + row_term(base, w, pw));
			acc_y = clamp_acc(acc_y + row_term(base + 4, w, pw));
			acc_z = clamp_acc(acc_z + row_term(base + 8, w, pw));
		end
		if (!w.last) begin
			return 1'b0;
		end
		v.x = clamp_out(acc_x);
		v.y = clamp_out(acc_y);
		v.z = clamp_out(acc_z);
		acc_x = 0;
		acc_y = 0;
		acc_z = 0;
		return 1'b1;
	endfunction

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 3))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// rotation-like lanes mostly stay near unit scale, translation lanes wider
	function automatic logic [COEF_W-1:0] pick_coef(input bit translation);
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return pick_extreme();
			default: begin
				if (translation) begin
					return 32'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
				end
				return 32'(int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
			end
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_pos();
		case ($urandom_range(0, 7))
			0: return $urandom();
			1: return pick_extreme();
			default: return 32'(int'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
		endcase
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return WEIGHT_ONE;
			2: return WEIGHT_W'($urandom_range(65537, 131071));
			3: return WEIGHT_W'(1);
			default: return WEIGHT_W'($urandom_range(1, 65535));
		endcase
	endfunction

	// loads carry random junk in the fields they do not use
	task automatic push_load(input int j, input int e, input logic [COEF_W-1:0] c,
			input logic lst);
		blend_word_t w;
		w.func    = FUNC_LOAD;
		w.joint   = JOINT_W'(j);
		w.element = ELEM_W'(e);
		w.coef    = c;
		w.pos_x   = $urandom();
		w.pos_y   = $urandom();
		w.pos_z   = $urandom();
		w.weight  = WEIGHT_W'($urandom());
		w.last    = lst;
		pending_words.push_back(w);
		if (e < XFORM_WORDS) begin
			stim_count++;
			gen_loaded[j][e] = 1'b1;
			if (&gen_loaded[j] && !gen_listed[j]) begin
				gen_listed[j] = 1'b1;
				ready_joints.push_back(j);
			end
		end
	endtask

	task automatic push_mac(input int j, input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
			input logic [POS_W-1:0] pz, input logic [WEIGHT_W-1:0] wt, input logic lst);
		blend_word_t w;
		w.func    = FUNC_MAC;
		w.joint   = JOINT_W'(j);
		w.element = ELEM_W'($urandom());
		w.coef    = $urandom();
		w.pos_x   = px;
		w.pos_y   = py;
		w.pos_z   = pz;
		w.weight  = wt;
		w.last    = lst;
		pending_words.push_back(w);
		stim_count++;
	endtask

	task automatic load_joint(input int j);
		for (int e = 0; e < XFORM_WORDS; e++) begin
			push_load(j, e, pick_coef(e % 4 == int'(LANE_OFFSET)), $urandom_range(0, 15) == 0);
		end
	endtask

	function automatic int pick_ready_joint();
		return ready_joints[$urandom_range(0, ready_joints.size() - 1)];
	endfunction

	task automatic push_vertex();
		int n;
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
		logic [POS_W-1:0] pz;
		n = $urandom_range(1, 4);
		px = pick_pos();
		py = pick_pos();
		pz = pick_pos();
		for (int k = 0; k < n; k++) begin
			push_mac(pick_ready_joint(), px, py, pz, pick_weight(), k == n - 1);
		end
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || s_axis_tvalid || expected_vertices.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// sender: offers queued words, bursts of idle between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= FUNC_LOAD;
			s_axis_tlast <= 1'b0;
			send_gap <= 0;
		end else begin : drive
			blend_word_t next_word;
			vertex_t emitted;
			if (s_axis_tvalid && s_axis_tready) begin
				if (blend_word(cur_word, emitted)) begin
					expected_vertices.push_back(emitted);
				end
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					next_word = pending_words.pop_front();
					cur_word <= next_word;
					s_axis_tdata <= S_TDATA_W'({next_word.weight, next_word.pos_z, next_word.pos_y,
						next_word.pos_x, next_word.coef, next_word.element, next_word.joint});
					s_axis_tuser <= next_word.func;
					s_axis_tlast <= next_word.last;
					s_axis_tvalid <= 1'b1;
					if (!calm && $urandom_range(0, 5) == 0) begin
						send_gap <= $urandom_range(1, 6);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_start) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver: checks each result word against the oldest expected vertex
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_gap <= 0;
		end else begin : watch
			vertex_t want;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_vertices.size() == 0) begin
					$error("result word %h arrived with no vertex expected", m_axis_tdata);
					fail_count++;
				end else begin
					want = expected_vertices.pop_front();
					if (m_axis_tdata[31:0] !== want.x) begin
						$error("out_x expected %0d actual %0d", $signed(want.x),
							$signed(m_axis_tdata[31:0]));
						fail_count++;
					end
					if (m_axis_tdata[63:32] !== want.y) begin
						$error("out_y expected %0d actual %0d", $signed(want.y),
							$signed(m_axis_tdata[63:32]));
						fail_count++;
					end
					if (m_axis_tdata[95:64] !== want.z) begin
						$error("out_z expected %0d actual %0d", $signed(want.z),
							$signed(m_axis_tdata[95:64]));
						fail_count++;
					end
				end
			end
			if (hold_left != 0 || hold_start) begin
				m_axis_tready <= 1'b0;
			end else if (sink_gap != 0) begin
				sink_gap <= sink_gap - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0) begin
					sink_gap <= $urandom_range(1, 6);
				end
			end
		end
	end

	initial begin
		cycles_run = 0;
		while (cycles_run < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles_run++;
		end
		$error("run stopped after %0d cycles without finishing", CYCLE_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int r;
		int chunk;
		int chunk_end;
		logic [COEF_W-1:0] c;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// top joint gets full-scale rows so every axis saturates
		for (int e = 0; e < XFORM_WORDS; e++) begin
			case (e / 4)
				0: c = 32'h7FFF_FFFF;
				1: c = 32'h8000_0000;
				default: c = (e % 2 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			endcase
			push_load(TOP_JOINT, e, c, e == XFORM_WORDS - 1);
		end
		push_load(TOP_JOINT, 15, $urandom(), 1'b1);
		push_load(TOP_JOINT, 12, $urandom(), 1'b0);
		push_mac(TOP_JOINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, WEIGHT_ONE, 1'b0);
		push_mac(TOP_JOINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'h1FFFF, 1'b0);
		push_mac(TOP_JOINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 17'd1, 1'b1);
		push_mac(TOP_JOINT, $urandom(), $urandom(), $urandom(), 17'd0, 1'b1);
		push_mac(TOP_JOINT, 32'h0, 32'h0, 32'h0, 17'hFFFF, 1'b1);
		push_mac(TOP_JOINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, WEIGHT_ONE, 1'b1);
		push_mac(TOP_JOINT, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 17'h8000, 1'b1);
		wait_drained();

		for (int k = 0; k < 6; k++) begin
			load_joint($urandom_range(0, TOP_JOINT));
		end
		chunk = 0;
		while (stim_count < ITEM_TARGET) begin
			while (pending_words.size() > 8) begin
				@(negedge clk);
			end
			chunk_end = stim_count + CHUNK_ITEMS;
			while (stim_count < chunk_end) begin
				r = $urandom_range(0, 99);
				if (r < 62) begin
					push_vertex();
				end else if (r < 72) begin
					c = $urandom_range(0, XFORM_WORDS - 1);
					push_load($urandom_range(0, TOP_JOINT), int'(c),
						pick_coef(int'(c) % 4 == int'(LANE_OFFSET)), 1'b0);
				end else if (r < 76) begin
					load_joint($urandom_range(0, TOP_JOINT));
				end else if (r < 84) begin
					// element past the transform: the block must drop it
					push_load($urandom_range(0, TOP_JOINT), $urandom_range(XFORM_WORDS, 15),
						$urandom(), 1'($urandom_range(0, 1)));
				end else if (r < 89) begin
					c = $urandom_range(0, XFORM_WORDS - 1);
					push_load($urandom_range(0, TOP_JOINT), int'(c),
						pick_coef(int'(c) % 4 == int'(LANE_OFFSET)), 1'b1);
				end else if (r < 95) begin
					// contribution with no last folds into the next vertex
					push_mac(pick_ready_joint(), pick_pos(), pick_pos(), pick_pos(),
						pick_weight(), 1'b0);
				end else begin
					push_mac(pick_ready_joint(), $urandom(), $urandom(), $urandom(), '0,
						1'($urandom_range(0, 1)));
				end
			end
			chunk++;
			if (chunk == 3) begin
				hold_start = 1'b1;
				@(negedge clk);
				hold_start = 1'b0;
			end
			if (chunk == 7) begin
				wait_drained();
			end
			if (stim_count >= ITEM_TARGET - CALM_ITEMS) begin
				calm = 1'b1;
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && expected_vertices.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/lbs_pkg.sv
hw/rtl/lbs_ram.sv
hw/rtl/linear_blend_skinning_core.sv
tb/testbench.sv
